>>> hdl/csrl_pkg.sv
// ----------------------------------------------------------------------------
// csrl_pkg
// Types and codes shared by the configuration stream RAM loader.
// ----------------------------------------------------------------------------
`default_nettype none

package csrl_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_DEVID   = 3'd1,
    KIND_CONTROL = 3'd2,
    KIND_WRITE   = 3'd3,
    KIND_DROP    = 3'd4
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [9:0] {
    PH_HUNT    = 10'b00_0000_0001,
    PH_SKIP    = 10'b00_0000_0010,
    PH_DEVID   = 10'b00_0000_0100,
    PH_CONTROL = 10'b00_0000_1000,
    PH_HOFS    = 10'b00_0001_0000,
    PH_HBANK   = 10'b00_0010_0000,
    PH_HCOUNT  = 10'b00_0100_0000,
    PH_DATA    = 10'b00_1000_0000,
    PH_CHECK   = 10'b01_0000_0000,
    PH_IDLE    = 10'b10_0000_0000
  } phase_e;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_SYNC_VALUE      = 2'd0;
  localparam cfg_index_t CFG_SKIP_AFTER_SYNC = 2'd1;

  localparam logic [7:0] SYNC_VALUE_RESET      = 8'hD5;
  localparam logic [2:0] SKIP_AFTER_SYNC_RESET = 3'd4;

  // Header byte 1 layout
  localparam int unsigned LONG_CHECK_BIT = 5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_config;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] bank_index;
    logic [4:0] byte_offset;
    logic [7:0] value;
  } out_item_t;

  // One configuration write request as seen by the parser
  typedef struct packed {
    logic       valid;
    cfg_index_t index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

>>> hdl/csrl_stream_if.sv
// ----------------------------------------------------------------------------
// csrl_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface csrl_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> hdl/csrl_cfg_if.sv
// ----------------------------------------------------------------------------
// csrl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface csrl_cfg_if;
  import csrl_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

>>> hdl/csrl_parser.sv
// ----------------------------------------------------------------------------
// csrl_parser
// Configuration registers, parse state and per-byte result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module csrl_parser #(
  parameter int unsigned NUM_BANKS  = 24,
  parameter int unsigned BANK_BYTES = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  csrl_pkg::cfg_wr_t    cfg_i,
  input  wire                  accept_i,
  input  csrl_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output csrl_pkg::out_item_t  res_item_o
);
  import csrl_pkg::*;

  localparam logic [8:0] NUM_BANKS_W = 9'(NUM_BANKS);
  localparam logic [5:0] BANK_BYTES_W = 6'(BANK_BYTES);
  localparam logic [5:0] LAST_OFS    = 6'(BANK_BYTES - 1);

  logic [7:0] sync_value_q;
  logic [2:0] skip_after_sync_q;

  phase_e     phase_q, phase_d;
  logic [2:0] skip_q, skip_d;
  logic [7:0] bank_q, bank_d;
  logic [4:0] ofs_q, ofs_d;
  logic [8:0] data_left_q, data_left_d;
  logic       long_q, long_d;
  logic [1:0] check_q, check_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q      <= SYNC_VALUE_RESET;
      skip_after_sync_q <= SKIP_AFTER_SYNC_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SYNC_VALUE:      sync_value_q      <= cfg_i.data;
        CFG_SKIP_AFTER_SYNC: skip_after_sync_q <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_e     ph;
    logic [7:0] b;
    logic [2:0] skip_dec;
    logic [8:0] left_dec;
    logic [1:0] check_dec;
    logic       in_range;

    b         = item_i.in_byte;
    ph        = phase_q;
    skip_d    = skip_q;
    bank_d    = bank_q;
    ofs_d     = ofs_q;
    data_left_d = data_left_q;
    long_d    = long_q;
    check_d   = check_q;
    phase_d   = phase_q;

    res_valid_o            = 1'b0;
    res_item_o.kind        = KIND_CLEAR;
    res_item_o.bank_index  = '0;
    res_item_o.byte_offset = '0;
    res_item_o.value       = '0;

    skip_dec  = skip_q - 3'd1;
    left_dec  = data_left_q - 9'd1;
    check_dec = check_q - 2'd1;
    in_range  = ({1'b0, bank_q} < NUM_BANKS_W) && ({1'b0, ofs_q} < BANK_BYTES_W);

    // Restart: clear result, then parse this byte from a fresh hunt
    if (item_i.start_of_config) begin
      ph          = PH_HUNT;
      skip_d      = '0;
      bank_d      = '0;
      ofs_d       = '0;
      data_left_d = '0;
      long_d      = 1'b0;
      check_d     = '0;
      res_valid_o = 1'b1;
      phase_d     = PH_HUNT;
    end

    unique case (ph)
      PH_HUNT: begin
        if (b == sync_value_q) begin
          skip_d  = skip_after_sync_q;
          phase_d = (skip_after_sync_q != 3'd0) ? PH_SKIP : PH_DEVID;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 3'd0) begin
          phase_d = PH_DEVID;
        end
      end
      PH_DEVID: begin
        res_valid_o      = 1'b1;
        res_item_o.kind  = KIND_DEVID;
        res_item_o.value = b;
        phase_d          = PH_CONTROL;
      end
      PH_CONTROL: begin
        res_valid_o      = 1'b1;
        res_item_o.kind  = KIND_CONTROL;
        res_item_o.value = b;
        phase_d          = PH_HOFS;
      end
      PH_HOFS: begin
        long_d  = b[LONG_CHECK_BIT];
        ofs_d   = b[4:0];
        phase_d = PH_HBANK;
      end
      PH_HBANK: begin
        bank_d  = b;
        phase_d = PH_HCOUNT;
      end
      PH_HCOUNT: begin
        // A count of zero stands for a full 256-byte block
        data_left_d = (b == 8'd0) ? 9'd256 : {1'b0, b};
        phase_d     = PH_DATA;
      end
      PH_DATA: begin
        res_valid_o            = 1'b1;
        res_item_o.kind        = in_range ? KIND_WRITE : KIND_DROP;
        res_item_o.bank_index  = bank_q[4:0];
        res_item_o.byte_offset = ofs_q;
        res_item_o.value       = b;
        if ({1'b0, ofs_q} >= LAST_OFS) begin
          ofs_d  = '0;
          bank_d = bank_q + 8'd1;
        end else begin
          ofs_d = ofs_q + 5'd1;
        end
        data_left_d = left_dec;
        if (left_dec == 9'd0) begin
          check_d = {1'b0, long_q} + 2'd1;
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        check_d = check_dec;
        if (check_dec == 2'd0) begin
          phase_d = PH_HOFS;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (item_i.final_byte) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      skip_q      <= '0;
      bank_q      <= '0;
      ofs_q       <= '0;
      data_left_q <= '0;
      long_q      <= 1'b0;
      check_q     <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      bank_q      <= bank_d;
      ofs_q       <= ofs_d;
      data_left_q <= data_left_d;
      long_q      <= long_d;
      check_q     <= check_d;
    end
  end

  a_data_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (data_left_q != 9'd0))
    else $error("data phase with no bytes left");

  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CHECK) |-> (check_q == 2'd1 || check_q == 2'd2))
    else $error("check byte count out of range");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.start_of_config) |-> (res_valid_o && res_item_o.kind == KIND_CLEAR))
    else $error("start request without clear result");

endmodule

`default_nettype wire

>>> hdl/csrl_out_buf.sv
// ----------------------------------------------------------------------------
// csrl_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module csrl_out_buf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  csrl_pkg::out_item_t  push_item_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output csrl_pkg::out_item_t  out_item_o
);
  import csrl_pkg::*;

  logic      main_v_q, skid_v_q;
  out_item_t main_q, skid_q;
  logic      pop;

  assign pop         = main_v_q && out_ready_i;
  assign space_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_item_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (!main_v_q || pop) begin
      main_v_q <= push_i;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (!main_v_q || pop) begin
      if (push_i) begin
        main_q <= push_item_i;
      end
    end else if (push_i) begin
      skid_q <= push_item_i;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry without output entry");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q)
    else $error("push into full buffer");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && pop) |=> (main_v_q && main_q == $past(skid_q)))
    else $error("skid entry lost on pop");

endmodule

`default_nettype wire

>>> hdl/config_stream_ram_loader.sv
// ----------------------------------------------------------------------------
// config_stream_ram_loader
// Parses a configuration byte stream into RAM clear, id, control and write results.
// ----------------------------------------------------------------------------
//  port    dir  kind         payload
//  in_i    in   stream sink  in_byte, start_of_config, final_byte
//  out_o   out  stream src   kind, bank_index, byte_offset, value
//  cfg_i   in   write sink   index (0 sync_value, 1 skip_after_sync), data
//
//  One byte per cycle while input ready is high: each accepted byte is decoded
//  combinationally and registered into the output buffer, giving zero or one result.
//  A two-entry output buffer keeps input ready high while one result waits.
//  Input ready drops only when both buffer entries hold results.
//  Reset puts the parser in sync hunt and loads sync 0xD5, skip 4.
//  Configuration writes are always ready and take effect next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module config_stream_ram_loader #(
  parameter int unsigned NUM_BANKS  = 24,
  parameter int unsigned BANK_BYTES = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  csrl_stream_if.sink   in_i,
  csrl_stream_if.source out_o,
  csrl_cfg_if.sink      cfg_i
);
  import csrl_pkg::*;

  cfg_wr_t   cfg_wr;
  in_item_t  in_item;
  out_item_t res_item;
  out_item_t buf_item;
  logic      space;
  logic      accept;
  logic      res_valid;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  assign in_item    = in_i.payload;
  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  csrl_parser #(
    .NUM_BANKS  (NUM_BANKS),
    .BANK_BYTES (BANK_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .accept_i    (accept),
    .item_i      (in_item),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  csrl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_item_i (res_item),
    .space_o     (space),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (buf_item)
  );

  assign out_o.payload = buf_item;

endmodule

`default_nettype wire

>>> test/config_stream_ram_loader_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// config_stream_ram_loader_test
// Self-checking bench for the configuration stream RAM loader. A directed
// stimulus table is followed by random configuration streams under several
// sync/skip settings. Every accepted byte runs through an in-bench parser
// model, and each result is compared field by field in order. Both channel
// sides idle at random, and the result side holds off once to fill the block.
// ----------------------------------------------------------------------------

module config_stream_ram_loader_test;
  import csrl_pkg::*;

  localparam int unsigned NUM_BANKS   = 24;
  localparam int unsigned BANK_BYTES  = 32;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_PAUSE = 4;

  typedef struct {
    logic [7:0] in_byte;
    bit         start;
    bit         fin;
    bit         pinned;
    kind_e      kind;
    logic [4:0] bank;
    logic [4:0] ofs;
    logic [7:0] val;
  } dir_row_t;

  typedef struct {
    bit        pinned;
    out_item_t result;
  } pin_t;

  logic clk;
  logic rst_n;

  csrl_stream_if #(.payload_t(in_item_t))  in_if ();
  csrl_stream_if #(.payload_t(out_item_t)) out_if ();
  csrl_cfg_if                              cfg_if ();

  config_stream_ram_loader #(
    .NUM_BANKS (NUM_BANKS),
    .BANK_BYTES(BANK_BYTES)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Parser model state
  logic [7:0] sync_reg;
  logic [2:0] skip_reg;
  phase_e     parse_ph;
  logic [2:0] skip_left;
  logic [7:0] bank_pos;
  logic [4:0] ofs_pos;
  logic [8:0] data_left;
  logic       long_chk;
  logic [1:0] chk_left;

  out_item_t   pending_results[$];
  pin_t        pin_q[$];
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on = 1'b0;
  bit          stall_req = 1'b0;
  bit          force_full = 1'b0;

  dir_row_t dir_rows [26] = '{
    '{8'h00, 1'b1, 1'b0, 1'b1, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hD5, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hAA, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h55, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hA5, 1'b0, 1'b0, 1'b1, KIND_DEVID,   5'd0,  5'd0,  8'hA5},
    '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_CONTROL, 5'd0,  5'd0,  8'hFF},
    '{8'h3F, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h17, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h02, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b1, KIND_WRITE,   5'd23, 5'd31, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_DROP,    5'd24, 5'd0,  8'hFF},
    '{8'h12, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h34, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h01, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h80, 1'b0, 1'b0, 1'b1, KIND_DROP,    5'd31, 5'd0,  8'h80},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h05, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h03, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'h11, 1'b0, 1'b1, 1'b1, KIND_WRITE,   5'd0,  5'd5,  8'h11},
    '{8'hD5, 1'b0, 1'b0, 1'b0, KIND_CLEAR,   5'd0,  5'd0,  8'h00},
    '{8'hD5, 1'b1, 1'b1, 1'b1, KIND_CLEAR,   5'd0,  5'd0,  8'h00}
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endfunction

  function automatic void reset_parser();
    sync_reg  = SYNC_VALUE_RESET;
    skip_reg  = SKIP_AFTER_SYNC_RESET;
    parse_ph  = PH_HUNT;
    skip_left = '0;
    bank_pos  = '0;
    ofs_pos   = '0;
    data_left = '0;
    long_chk  = 1'b0;
    chk_left  = '0;
  endfunction

  function automatic void parse_stream_byte(in_item_t it);
    out_item_t res;
    bit        has_res;
    bit        in_range;
    pin_t      pin;
    logic [7:0] b;
    res     = '0;
    has_res = 1'b0;
    b       = it.in_byte;
    if (it.start_of_config) begin
      parse_ph  = PH_HUNT;
      skip_left = '0;
      bank_pos  = '0;
      ofs_pos   = '0;
      data_left = '0;
      long_chk  = 1'b0;
      chk_left  = '0;
      res.kind  = KIND_CLEAR;
      has_res   = 1'b1;
    end
    case (parse_ph)
      PH_HUNT: begin
        if (b == sync_reg) begin
          skip_left = skip_reg;
          parse_ph  = (skip_reg != 0) ? PH_SKIP : PH_DEVID;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 3'd1;
        if (skip_left == 0) parse_ph = PH_DEVID;
      end
      PH_DEVID: begin
        res      = '{KIND_DEVID, 5'd0, 5'd0, b};
        has_res  = 1'b1;
        parse_ph = PH_CONTROL;
      end
      PH_CONTROL: begin
        res      = '{KIND_CONTROL, 5'd0, 5'd0, b};
        has_res  = 1'b1;
        parse_ph = PH_HOFS;
      end
      PH_HOFS: begin
        long_chk = b[LONG_CHECK_BIT];
        ofs_pos  = b[4:0];
        parse_ph = PH_HBANK;
      end
      PH_HBANK: begin
        bank_pos = b;
        parse_ph = PH_HCOUNT;
      end
      PH_HCOUNT: begin
        data_left = (b == 0) ? 9'd256 : {1'b0, b};
        parse_ph  = PH_DATA;
      end
      PH_DATA: begin
        in_range        = (bank_pos < NUM_BANKS) && (ofs_pos < BANK_BYTES);
        res.kind        = in_range ? KIND_WRITE : KIND_DROP;
        res.bank_index  = bank_pos[4:0];
        res.byte_offset = ofs_pos;
        res.value       = b;
        has_res         = 1'b1;
        if (ofs_pos >= BANK_BYTES - 1) begin
          ofs_pos  = '0;
          bank_pos = bank_pos + 8'd1;
        end else begin
          ofs_pos = ofs_pos + 5'd1;
        end
        data_left = data_left - 9'd1;
        if (data_left == 0) begin
          chk_left = 2'd1 + {1'b0, long_chk};
          parse_ph = PH_CHECK;
        end
      end
      PH_CHECK: begin
        chk_left = chk_left - 2'd1;
        if (chk_left == 0) parse_ph = PH_HOFS;
      end
      default: parse_ph = PH_IDLE;
    endcase
    if (it.final_byte) parse_ph = PH_IDLE;
    // Typed-in results from the directed table take precedence
    if (pin_q.size() != 0) begin
      pin = pin_q.pop_front();
      if (pin.pinned) begin
        res     = pin.result;
        has_res = 1'b1;
      end
    end
    if (has_res) pending_results.push_back(res);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) parse_stream_byte(in_if.payload);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_SYNC_VALUE:      sync_reg = cfg_if.data;
        CFG_SKIP_AFTER_SYNC: skip_reg = cfg_if.data[2:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value 0x%0h",
                                  got.kind, got.value));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("bank_index", got.bank_index, want.bank_index);
        check_field("byte_offset", got.byte_offset, want.byte_offset);
        check_field("value", got.value, want.value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("config_stream_ram_loader_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random idling, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_if.ready <= !idle_on || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic push_item(in_item_t it);
    while (idle_on && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] sync_v, logic [2:0] skip_v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SYNC_VALUE;
    cfg_if.data  <= sync_v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_SKIP_AFTER_SYNC;
    cfg_if.data  <= {5'd0, skip_v};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    // Let the model registers settle before streams are built from them
    @(posedge clk);
  endtask

  // Build one configuration stream, break some of them, and send it
  task automatic send_stream(inout int unsigned used);
    in_item_t    s[$];
    int unsigned nblk;
    int unsigned cnt;
    int unsigned cut;
    int unsigned pick;
    logic [7:0]  hb;
    logic [7:0]  bk;
    logic [7:0]  nb;
    s.push_back('{8'($urandom), 1'b1, 1'b0});
    repeat ($urandom_range(2)) begin
      nb = 8'($urandom);
      if (nb == sync_reg) nb = nb ^ 8'h01;
      s.push_back('{nb, 1'b0, 1'b0});
    end
    s.push_back('{sync_reg, 1'b0, 1'b0});
    repeat (skip_reg) s.push_back('{8'($urandom), 1'b0, 1'b0});
    s.push_back('{8'($urandom), 1'b0, 1'b0});
    s.push_back('{8'($urandom), 1'b0, 1'b0});
    nblk = $urandom_range(1, 3);
    repeat (nblk) begin
      hb = 8'($urandom);
      pick = $urandom_range(9);
      if (pick <= 5)      bk = 8'($urandom_range(0, NUM_BANKS - 1));
      else if (pick <= 7) bk = 8'($urandom_range(NUM_BANKS - 2, NUM_BANKS + 1));
      else if (pick == 8) bk = 8'hFF;
      else                bk = 8'($urandom);
      if (force_full) begin
        cnt = 0;
        force_full = 1'b0;
      end else begin
        cnt = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 6);
      end
      s.push_back('{hb, 1'b0, 1'b0});
      s.push_back('{bk, 1'b0, 1'b0});
      s.push_back('{8'(cnt), 1'b0, 1'b0});
      repeat ((cnt == 0) ? 256 : cnt) s.push_back('{8'($urandom), 1'b0, 1'b0});
      repeat (1 + hb[LONG_CHECK_BIT]) s.push_back('{8'($urandom), 1'b0, 1'b0});
    end
    pick = $urandom_range(99);
    if (pick < 12) begin
      // Truncate mid-stream
      cut = $urandom_range(0, s.size() - 1);
      while (s.size() > cut + 1) void'(s.pop_back());
      s[s.size() - 1].final_byte = 1'b1;
    end else if (pick < 20) begin
      // Restart somewhere inside the stream
      s[$urandom_range(1, s.size() - 1)].start_of_config = 1'b1;
      s[s.size() - 1].final_byte = $urandom_range(1);
    end else begin
      s[s.size() - 1].final_byte = ($urandom_range(99) < 85);
    end
    foreach (s[i]) push_item(s[i]);
    used += s.size();
    // Trailing bytes, mostly ignored by an idle parser
    repeat ($urandom_range(2)) push_item('{8'($urandom), 1'b0, 1'($urandom_range(1))});
  endtask

  initial begin
    int unsigned used;
    logic [7:0]  sync_v;
    logic [2:0]  skip_v;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_SYNC_VALUE;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    reset_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    foreach (dir_rows[i]) begin
      pin_q.push_back('{dir_rows[i].pinned,
                        '{dir_rows[i].kind, dir_rows[i].bank, dir_rows[i].ofs,
                          dir_rows[i].val}});
      push_item('{dir_rows[i].in_byte, dir_rows[i].start, dir_rows[i].fin});
    end
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin sync_v = 8'h00; skip_v = 3'd0; end
        1:       begin sync_v = 8'hFF; skip_v = 3'd7; end
        2:       begin sync_v = 8'hD5; skip_v = 3'd3; end
        default: begin sync_v = 8'($urandom); skip_v = 3'($urandom_range(1, 6)); end
      endcase
      set_config(sync_v, skip_v);
      idle_on    = (p != 2);
      stall_req  = (p == 1);
      force_full = (p == 0);
      used = 0;
      while (used < PHASE_ITEMS) send_stream(used);
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("config_stream_ram_loader_test: done, clean");
    end else begin
      $display("config_stream_ram_loader_test: done, errors");
    end
    $finish;
  end

endmodule
